[design/contactor_cooldown_sequencer_top_defines.svh]
// Assertion macros used by the port-level checker of the cool-down sequencer.
`ifndef CONTACTOR_COOLDOWN_SEQUENCER_TOP_DEFINES_SVH
`define CONTACTOR_COOLDOWN_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define CCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[design/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the contactor cool-down sequencer.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // Phase codes.
  localparam logic [1:0] PH_COOLING  = 2'd0;
  localparam logic [1:0] PH_COOL     = 2'd1;
  localparam logic [1:0] PH_POWERING = 2'd2;
  localparam logic [1:0] PH_ON       = 2'd3;

  // Item kinds.
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_REQ_C1 = 2'd1;
  localparam logic [1:0] FN_REQ_C2 = 2'd2;
  localparam logic [1:0] FN_OFF    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_COOLDOWN = 2'd0;
  localparam logic [1:0] CFG_STEP_DELAY   = 2'd1;
  localparam logic [1:0] CFG_TWO_CONTACT  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] MIN_COOLDOWN_RST = 16'd30;
  localparam logic [7:0]  STEP_DELAY_RST   = 8'd6;
  localparam logic        TWO_CONTACT_RST  = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // One result item.
  typedef struct packed {
    logic [15:0] cooldown_left_s;
    logic        ready_res;
    logic [1:0]  phase;
    logic        contactor2_on;
    logic        contactor1_on;
  } result_t;

endpackage

[design/ccs_core.sv]
// ----------------------------------------------------------------------------
// ccs_core
// Input register, configuration registers, sequencer state and next-state
// logic. Produces one result per item for the result register.
// ----------------------------------------------------------------------------
module ccs_core
  import ccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic                  in_err,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  // Configuration.
  logic [15:0] min_cooldown;
  logic [7:0]  step_delay;
  logic        two_contact;

  // Input register.
  logic       item_valid;
  logic [1:0] item_func;
  logic       item_err;

  // Sequencer state.
  logic [1:0]  phase_reg,    phase_reg_next;
  logic [7:0]  delay_count,  delay_count_next;
  logic        want_first,   want_first_next;
  logic        want_second,  want_second_next;
  logic        want_off,     want_off_next;
  logic        drive_first,  drive_first_next;
  logic        drive_second, drive_second_next;
  logic [15:0] secs_since_hot, secs_since_hot_next;

  logic [15:0] secs_inc;
  logic        advance;

  assign advance   = item_valid && res_ready;
  assign in_ready  = !item_valid || res_ready;
  assign res_valid = item_valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cooldown <= MIN_COOLDOWN_RST;
      step_delay   <= STEP_DELAY_RST;
      two_contact  <= TWO_CONTACT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_COOLDOWN: min_cooldown <= cfg_data[15:0];
        CFG_STEP_DELAY:   step_delay   <= cfg_data[7:0];
        CFG_TWO_CONTACT:  two_contact  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_func <= in_func;
      item_err  <= in_err;
    end
  end

  // Seconds counter saturates at its top value.
  assign secs_inc = (secs_since_hot == 16'hFFFF) ? secs_since_hot
                                                 : secs_since_hot + 16'd1;

  // Next-state logic for one item.
  always_comb begin
    phase_reg_next      = phase_reg;
    delay_count_next    = delay_count;
    want_first_next     = want_first;
    want_second_next    = want_second;
    want_off_next       = want_off;
    drive_first_next    = drive_first;
    drive_second_next   = drive_second;
    secs_since_hot_next = secs_since_hot;
    case (item_func)
      FN_TICK: begin
        case (phase_reg)
          PH_COOLING: begin
            drive_first_next  = 1'b0;
            drive_second_next = 1'b0;
            if (delay_count != 8'd0) begin
              delay_count_next = delay_count - 8'd1;
            end else if (secs_inc >= min_cooldown) begin
              want_off_next    = 1'b0;
              phase_reg_next   = PH_COOL;
              delay_count_next = 8'd0;
            end
          end
          PH_COOL: begin
            drive_first_next  = 1'b0;
            drive_second_next = 1'b0;
            if (!item_err && (want_first || want_second)) begin
              want_first_next  = 1'b0;
              drive_first_next = 1'b1;
              delay_count_next = step_delay;
              phase_reg_next   = PH_POWERING;
            end
          end
          PH_POWERING: begin
            if (item_err || want_off) begin
              drive_first_next  = 1'b0;
              drive_second_next = 1'b0;
              want_first_next   = 1'b0;
              want_second_next  = 1'b0;
              want_off_next     = 1'b0;
              delay_count_next  = step_delay;
              phase_reg_next    = PH_COOLING;
            end else if (delay_count != 8'd0) begin
              delay_count_next = delay_count - 8'd1;
            end else if (two_contact) begin
              // Hand over from contactor 1 to contactor 2 once requested.
              if (want_second) begin
                drive_first_next  = 1'b0;
                drive_second_next = 1'b1;
                phase_reg_next    = PH_ON;
                want_second_next  = 1'b0;
              end
            end else begin
              phase_reg_next   = PH_ON;
              want_second_next = 1'b0;
            end
          end
          default: begin
            if (item_err || want_off) begin
              drive_first_next  = 1'b0;
              drive_second_next = 1'b0;
              want_first_next   = 1'b0;
              want_second_next  = 1'b0;
              want_off_next     = 1'b0;
              delay_count_next  = step_delay;
              phase_reg_next    = PH_COOLING;
            end
          end
        endcase
        // Contactor 1 still driven at the end of the tick restarts cooling.
        secs_since_hot_next = drive_first_next ? 16'd0 : secs_inc;
      end
      FN_REQ_C1: begin
        want_first_next  = 1'b1;
        want_second_next = 1'b0;
        want_off_next    = 1'b0;
      end
      FN_REQ_C2: begin
        want_first_next  = 1'b0;
        want_second_next = 1'b1;
        want_off_next    = 1'b0;
      end
      default: begin
        drive_first_next  = 1'b0;
        drive_second_next = 1'b0;
        want_first_next   = 1'b0;
        want_second_next  = 1'b0;
        want_off_next     = 1'b1;
      end
    endcase
  end

  // State update, one item per transfer into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_COOLING;
      delay_count    <= STEP_DELAY_RST;
      want_first     <= 1'b0;
      want_second    <= 1'b0;
      want_off       <= 1'b0;
      drive_first    <= 1'b0;
      drive_second   <= 1'b0;
      secs_since_hot <= 16'd0;
    end else if (advance) begin
      phase_reg      <= phase_reg_next;
      delay_count    <= delay_count_next;
      want_first     <= want_first_next;
      want_second    <= want_second_next;
      want_off       <= want_off_next;
      drive_first    <= drive_first_next;
      drive_second   <= drive_second_next;
      secs_since_hot <= secs_since_hot_next;
    end
  end

  // Result fields from the state after this item.
  always_comb begin
    res.contactor1_on = drive_first_next;
    res.contactor2_on = drive_second_next;
    res.phase         = phase_reg_next;
    res.ready_res     = (phase_reg_next == PH_ON);
    if (secs_since_hot_next < min_cooldown) begin
      res.cooldown_left_s = min_cooldown - secs_since_hot_next;
    end else if (phase_reg_next == PH_COOLING) begin
      res.cooldown_left_s = {8'd0, delay_count_next};
    end else begin
      res.cooldown_left_s = 16'd0;
    end
  end

endmodule

[design/ccs_out_reg.sv]
// ----------------------------------------------------------------------------
// ccs_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module ccs_out_reg
  import ccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  output logic                  res_ready,
  input  result_t               res,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  result_t held;

  assign res_ready = !m_tvalid || m_tready;

  // Valid flag follows the upstream transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, held};

endmodule

[design/contactor_cooldown_sequencer_top.sv]
// ----------------------------------------------------------------------------
// contactor_cooldown_sequencer_top
// An input transfer passes the input register, then the result register.
// Throughput: one item per cycle while m_tready is high; the single-step
// next-state logic between the two registers handles a whole item at once.
// Reset (synchronous, rst high): both contactors off, phase cooling down,
// delay count 6, registers at 30 s / 6 ticks / two contactors.
// ----------------------------------------------------------------------------
module contactor_cooldown_sequencer_top
  import ccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] error_present
  input  logic [1:0]            s_tuser,   // [1:0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] contactor1_on, [1] contactor2_on, [3:2] phase, [4] ready_res,
  // [20:5] cooldown_left_s
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Sequencer state and next-state logic.
  ccs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_err    (s_tdata[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Result register toward the sink.
  ccs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[design/ccs_checker.sv]
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks of the cool-down sequencer results, bound to the top.
// ----------------------------------------------------------------------------
`include "contactor_cooldown_sequencer_top_defines.svh"

module ccs_checker
  import ccs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // Ready flag matches the on phase.
  `CCS_ASSERT_NOW(a_ready_on, clk, rst, m_tvalid, m_tdata[4] == (m_tdata[3:2] == PH_ON))

  // Contactor 2 is driven only in the on phase.
  `CCS_ASSERT_NOW(a_c2_only_on, clk, rst, m_tvalid && m_tdata[1], m_tdata[3:2] == PH_ON)

  // The two contactors are never driven together.
  `CCS_ASSERT_NOW(a_not_both, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[1]))

  // A stalled result holds.
  `CCS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind contactor_cooldown_sequencer_top ccs_checker u_ccs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/contactor_cooldown_sequencer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contactor_cooldown_sequencer_checker
// Watches the input, result and register-write ports of the cool-down
// sequencer. It keeps its own copy of the sequencer state and registers,
// works out the status that each accepted input should produce, and
// compares every result transfer with the oldest outstanding status.
// ----------------------------------------------------------------------------
module contactor_cooldown_sequencer_checker
  import ccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] error_present
  input  logic [1:0]            s_tuser,   // [1:0] func
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] contactor1_on, [1] contactor2_on, [3:2] phase, [4] ready_res,
  // [20:5] cooldown_left_s
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    awaiting
);

  localparam int RES_W = $bits(result_t);

  // Register copy.
  logic [15:0] min_cool;
  logic [7:0]  step_delay;
  logic        two_c;

  // Sequencer state copy.
  logic [1:0]  phase_q;
  logic [7:0]  delay_q;
  logic        want_c1;
  logic        want_c2;
  logic        want_off;
  logic        drive_c1;
  logic        drive_c2;
  logic [15:0] secs_cold;

  // Status words still owed by the block, oldest first.
  result_t     status_q[$];
  int          results_seen;

  initial begin
    mismatches   = 0;
    awaiting     = 0;
    results_seen = 0;
  end

  // Fault or off: drop everything and restart the cool-down delay.
  function automatic void drop_to_cooling();
    drive_c1 = 1'b0;
    drive_c2 = 1'b0;
    want_c1  = 1'b0;
    want_c2  = 1'b0;
    want_off = 1'b0;
    delay_q  = step_delay;
    phase_q  = PH_COOLING;
  endfunction

  // Applies one input item to the state copy and returns the status it yields.
  function automatic result_t advance_sequencer(input logic [1:0] fn, input logic err);
    result_t r;
    case (fn)
      FN_TICK: begin
        // Time since contactor 1 was last driven saturates at full scale.
        if (secs_cold != 16'hFFFF) secs_cold = secs_cold + 16'd1;
        case (phase_q)
          PH_COOLING: begin
            drive_c1 = 1'b0;
            drive_c2 = 1'b0;
            if (delay_q != 8'd0) begin
              delay_q = delay_q - 8'd1;
            end else if (secs_cold >= min_cool) begin
              want_off = 1'b0;
              phase_q  = PH_COOL;
              delay_q  = 8'd0;
            end
          end
          PH_COOL: begin
            drive_c1 = 1'b0;
            drive_c2 = 1'b0;
            if (!err && (want_c1 || want_c2)) begin
              want_c1  = 1'b0;
              drive_c1 = 1'b1;
              delay_q  = step_delay;
              phase_q  = PH_POWERING;
            end
          end
          PH_POWERING: begin
            if (err || want_off) begin
              drop_to_cooling();
            end else if (delay_q != 8'd0) begin
              delay_q = delay_q - 8'd1;
            end else if (two_c) begin
              // Hand over from contactor 1 to contactor 2 once asked for.
              if (want_c2) begin
                drive_c1 = 1'b0;
                drive_c2 = 1'b1;
                phase_q  = PH_ON;
                want_c2  = 1'b0;
              end
            end else begin
              phase_q = PH_ON;
              want_c2 = 1'b0;
            end
          end
          default: begin
            if (err || want_off) drop_to_cooling();
          end
        endcase
        if (drive_c1) secs_cold = 16'd0;
      end
      FN_REQ_C1: begin
        want_c1  = 1'b1;
        want_c2  = 1'b0;
        want_off = 1'b0;
      end
      FN_REQ_C2: begin
        want_c1  = 1'b0;
        want_c2  = 1'b1;
        want_off = 1'b0;
      end
      default: begin
        // Off drops both outputs now; the phase follows on the next tick.
        drive_c1 = 1'b0;
        drive_c2 = 1'b0;
        want_c1  = 1'b0;
        want_c2  = 1'b0;
        want_off = 1'b1;
      end
    endcase

    r.contactor1_on = drive_c1;
    r.contactor2_on = drive_c2;
    r.phase         = phase_q;
    r.ready_res     = (phase_q == PH_ON);
    if (secs_cold < min_cool) r.cooldown_left_s = min_cool - secs_cold;
    else if (phase_q == PH_COOLING) r.cooldown_left_s = {8'h00, delay_q};
    else r.cooldown_left_s = 16'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 100)
      $display("%0t: result %0d, %s is %0d, expected %0d",
               $time, results_seen, field, got, want);
    mismatches++;
  endtask

  // Track register writes, predict on input transfers, check result transfers.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      min_cool   = MIN_COOLDOWN_RST;
      step_delay = STEP_DELAY_RST;
      two_c      = TWO_CONTACT_RST;
      drop_to_cooling();
      secs_cold  = 16'd0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_COOLDOWN: min_cool   = cfg_data[15:0];
          CFG_STEP_DELAY:   step_delay = cfg_data[7:0];
          CFG_TWO_CONTACT:  two_c      = cfg_data[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata[RES_W-1:0]);
        if (status_q.size() == 0) begin
          report_mismatch("unexpected transfer, tdata", 32'(m_tdata), 32'd0);
        end else begin
          want = status_q.pop_front();
          if (seen.contactor1_on != want.contactor1_on)
            report_mismatch("contactor1_on", 32'(seen.contactor1_on),
                            32'(want.contactor1_on));
          if (seen.contactor2_on != want.contactor2_on)
            report_mismatch("contactor2_on", 32'(seen.contactor2_on),
                            32'(want.contactor2_on));
          if (seen.phase != want.phase)
            report_mismatch("phase", 32'(seen.phase), 32'(want.phase));
          if (seen.ready_res != want.ready_res)
            report_mismatch("ready_res", 32'(seen.ready_res), 32'(want.ready_res));
          if (seen.cooldown_left_s != want.cooldown_left_s)
            report_mismatch("cooldown_left_s", 32'(seen.cooldown_left_s),
                            32'(want.cooldown_left_s));
          if (m_tdata[OUT_DATA_W-1:RES_W] != '0)
            report_mismatch("padding", 32'(m_tdata[OUT_DATA_W-1:RES_W]), 32'd0);
        end
        results_seen++;
      end

      if (s_tvalid && s_tready)
        status_q.push_back(advance_sequencer(s_tuser, s_tdata[0]));
    end
    awaiting <= status_q.size();
  end

endmodule

[tb/contactor_cooldown_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contactor_cooldown_sequencer_top_tb
// Drives ticks and contactor requests into the cool-down sequencer through
// a short directed walk over every phase, then random traffic under several
// register settings, including a long uninterrupted cool-down. Both ports
// idle at random; the result side holds off once for a long stretch while
// items keep coming. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module contactor_cooldown_sequencer_top_tb;
  import ccs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [0] error_present
  logic [1:0]            s_tuser;   // [1:0] func
  logic                  m_tvalid;
  logic                  m_tready;
  // [0] contactor1_on, [1] contactor2_on, [3:2] phase, [4] ready_res,
  // [20:5] cooldown_left_s
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int awaiting;

  // Shared with the result sink.
  bit gaps_on      = 1'b1;
  bit hold_off_req = 1'b0;

  contactor_cooldown_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  contactor_cooldown_sequencer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if neither port moves a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offer one item, with an optional idle burst first, and wait for its transfer.
  task automatic send_item(input logic [1:0] fn, input logic err);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {{(IN_DATA_W-1){1'b0}}, err};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly ticks with occasional faults; enough requests to leave cool quickly.
  task automatic send_random_item();
    int pick;
    logic [1:0] fn;
    pick = $urandom_range(0, 99);
    if (pick < 68) fn = FN_TICK;
    else if (pick < 80) fn = FN_REQ_C1;
    else if (pick < 92) fn = FN_REQ_C2;
    else fn = FN_OFF;
    send_item(fn, $urandom_range(0, 99) < 7);
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] min_s, input logic [7:0] delay_s,
                                input logic two);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_COOLDOWN;
    cfg_data  <= min_s;
    @(posedge clk);
    cfg_index <= CFG_STEP_DELAY;
    cfg_data  <= {8'h00, delay_s};
    @(posedge clk);
    cfg_index <= CFG_TWO_CONTACT;
    cfg_data  <= {15'h0000, two};
    @(posedge clk);
    cfg_we    <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(input logic [15:0] min_s, input logic [7:0] delay_s,
                              input logic two, input int count, input bit allow_gaps,
                              input bit hold_off);
    apply_settings(min_s, delay_s, two);
    gaps_on = allow_gaps;
    for (int i = 0; i < count; i++) begin
      // Switch idling on and off in stretches.
      if (allow_gaps && i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      // The sink stalls for a long stretch while items keep coming.
      if (hold_off && i == 20) hold_off_req = 1'b1;
      send_random_item();
    end
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FN_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MIN_COOLDOWN;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: short cool-down, one delay tick, two contactors.
    apply_settings(16'd2, 8'd1, 1'b1);
    send_item(FN_REQ_C1, 1'b1);            // request while still cooling down
    for (int i = 0; i < 7; i++)
      send_item(FN_TICK, i[0]);            // faults do not matter while cooling
    send_item(FN_REQ_C2, 1'b1);            // fault flag ignored on requests
    send_item(FN_TICK, 1'b1);              // fault keeps it in cool
    send_item(FN_TICK, 1'b0);              // powering up on contactor 1
    send_item(FN_TICK, 1'b0);
    send_item(FN_TICK, 1'b0);              // transfer to contactor 2
    send_item(FN_REQ_C1, 1'b0);
    send_item(FN_TICK, 1'b1);              // fault while on
    send_item(FN_TICK, 1'b0);
    send_item(FN_TICK, 1'b0);
    send_item(FN_REQ_C1, 1'b0);
    send_item(FN_TICK, 1'b0);
    send_item(FN_TICK, 1'b0);
    send_item(FN_TICK, 1'b0);              // waits with contactor 1 held
    send_item(FN_TICK, 1'b1);              // fault while powering up
    send_item(FN_OFF, 1'b1);
    send_item(FN_TICK, 1'b0);
    send_item(FN_TICK, 1'b0);

    // Random traffic under several settings; the sink stalls hard once.
    random_phase(MIN_COOLDOWN_RST, STEP_DELAY_RST, TWO_CONTACT_RST, 150, 1'b1, 1'b0);
    random_phase(16'd0, 8'd0, 1'b1, 150, 1'b1, 1'b1);
    random_phase(16'd0, 8'd0, 1'b0, 150, 1'b1, 1'b0);
    random_phase(16'd4, 8'd2, 1'b0, 150, 1'b1, 1'b0);
    random_phase(16'($urandom_range(1, 40)), 8'($urandom_range(0, 5)), 1'b1, 150, 1'b1,
                 1'b0);
    random_phase(16'd9, 8'd255, 1'b0, 120, 1'b1, 1'b0);

    // Long cool-down: the count of remaining seconds runs all the way down.
    apply_settings(16'd50, 8'd0, 1'b1);
    gaps_on = 1'b1;
    send_item(FN_OFF, 1'b0);
    for (int i = 0; i < 60; i++)
      send_item(FN_TICK, $urandom_range(0, 99) < 7);

    // Closing stretch without any idling.
    random_phase(16'd3, 8'd1, 1'b1, 120, 1'b0, 1'b0);

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[contactor_cooldown_sequencer_top.f]
+incdir+design
design/ccs_pkg.sv
design/ccs_core.sv
design/ccs_out_reg.sv
design/contactor_cooldown_sequencer_top.sv
design/ccs_checker.sv
tb/contactor_cooldown_sequencer_checker.sv
tb/contactor_cooldown_sequencer_top_tb.sv
